// ===== hw/rtl/ksm_pkg.sv =====
// Package for the key sequence matcher: field widths, operation codes and
// the reset value of the first key code register.
// No dependencies; imported by key_sequence_matcher_top.
package ksm_pkg;

    typedef logic [7:0] t_byte;

    localparam int unsigned KEY_W      = 8;
    localparam int unsigned IDX_W      = 5;
    localparam int unsigned BYTES_W    = 32;
    localparam int unsigned IN_TDATA_W = 48;
    localparam int unsigned SEQ_BYTES  = 4;

    localparam logic OP_TABLE_WRITE = 1'b0;
    localparam logic OP_KEY_BYTE    = 1'b1;

    localparam t_byte FIRST_KEY_CODE_RST = 8'd128;

endpackage

// ===== hw/rtl/key_sequence_matcher_top.sv =====
// Terminal key escape sequence matcher: sequence table, byte buffer and a
// sequencer around one shared byte comparator.
// Depends on ksm_pkg.
//
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata: index, bytes, key; tuser: operation
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: key_value; tuser: is_sequence
// cfg       in         i_cfg_valid/o_cfg_ready       i_cfg_data: first_key_code
//
// A table write is stored as it is accepted. A key byte is accepted, then table entries
// are scanned for its first byte, up to three more bytes are compared per candidate entry
// and a closing step loads the result, unless an entry waits for a byte not yet received.
// The single byte comparator reads one table byte a cycle.
// Synchronous active-low reset clears the table, the buffer and all control state.
// The input is not ready while a key byte is being worked on; a result waits in the
// output register, and work only stalls when a new result meets a full output register.
module key_sequence_matcher_top
    import ksm_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 17
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [4:0] entry_index, [36:5] entry_bytes, [44:37] key_byte, [47:45] zero
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    // [0] operation
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] key_value
    output logic [KEY_W-1:0]      m_axis_tdata,
    // [0] is_sequence
    output logic                  m_axis_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [KEY_W-1:0]      i_cfg_data
);

    localparam int unsigned EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_ADV    = 2'd2;

    localparam logic [EW:0] ENT_END = (EW + 1)'(TABLE_ENTRIES);

    logic [BYTES_W-1:0] r_table [TABLE_ENTRIES];
    t_byte              r_read_bytes [SEQ_BYTES];
    t_byte              n_read_bytes [SEQ_BYTES];
    logic [1:0]         r_state, n_state;
    logic [EW:0]        r_ent, n_ent;
    logic [2:0]         r_pos, n_pos;
    logic [1:0]         r_bri, n_bri;
    logic [EW-1:0]      r_cur_entry, n_cur_entry;
    logic [1:0]         r_cmp_pos, n_cmp_pos;
    logic               r_pending, n_pending;
    t_byte              r_first_code;
    logic               r_out_valid, n_out_valid;
    t_byte              r_out_value, n_out_value;
    logic               r_out_seq, n_out_seq;

    logic [IDX_W-1:0]   w_idx;
    logic [BYTES_W-1:0] w_bytes;
    t_byte              w_key;
    logic               w_in_acc;
    logic               w_slot_free;
    logic [BYTES_W-1:0] w_word;
    logic [1:0]         w_bpos;
    t_byte              w_byte;
    t_byte              w_cmp_b;
    logic               w_equal;

    assign w_idx   = s_axis_tdata[IDX_W-1:0];
    assign w_bytes = s_axis_tdata[IDX_W+BYTES_W-1:IDX_W];
    assign w_key   = s_axis_tdata[IDX_W+BYTES_W+KEY_W-1:IDX_W+BYTES_W];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_slot_free   = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_seq;

    // Shared comparator: one table byte against one buffered byte.
    assign w_word  = (r_ent < ENT_END) ? r_table[r_ent[EW-1:0]] : '0;
    assign w_bpos  = (r_state == ST_ADV) ? r_pos[1:0] : 2'd0;
    assign w_byte  = w_word[8*w_bpos +: 8];
    assign w_cmp_b = (r_state == ST_ADV) ? r_read_bytes[r_pos[1:0]] : r_read_bytes[0];
    assign w_equal = (w_byte == w_cmp_b);

    always_comb begin
        n_state      = r_state;
        n_ent        = r_ent;
        n_pos        = r_pos;
        n_bri        = r_bri;
        n_cur_entry  = r_cur_entry;
        n_cmp_pos    = r_cmp_pos;
        n_pending    = r_pending;
        n_read_bytes = r_read_bytes;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_value  = r_out_value;
        n_out_seq    = r_out_seq;

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (s_axis_tuser == OP_KEY_BYTE)) begin
                    n_pending = 1'b0;
                    if (r_pending) begin
                        n_read_bytes[r_cmp_pos] = w_key;
                        n_bri   = r_cmp_pos;
                        n_ent   = {1'b0, r_cur_entry};
                        n_pos   = {1'b0, r_cmp_pos};
                        n_state = ST_ADV;
                    end else begin
                        n_read_bytes[0] = w_key;
                        n_bri   = 2'd0;
                        n_ent   = '0;
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (r_ent == ENT_END) begin
                    // No candidate left: the last byte read goes out raw.
                    if (w_slot_free) begin
                        n_out_valid = 1'b1;
                        n_out_value = r_read_bytes[r_bri];
                        n_out_seq   = 1'b0;
                        n_state     = ST_IDLE;
                    end
                end else if (w_equal) begin
                    n_pos   = 3'd1;
                    n_state = ST_ADV;
                end else begin
                    n_ent = r_ent + 1'b1;
                end
            end
            ST_ADV: begin
                if (r_pos[2] || (w_byte == 8'd0)) begin
                    if (w_slot_free) begin
                        n_out_valid = 1'b1;
                        n_out_value = r_first_code + 8'(r_ent);
                        n_out_seq   = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end else if (r_pos[1:0] > r_bri) begin
                    // The entry is still alive but needs a byte not yet received.
                    n_pending   = 1'b1;
                    n_cur_entry = r_ent[EW-1:0];
                    n_cmp_pos   = r_pos[1:0];
                    n_state     = ST_IDLE;
                end else if (!w_equal) begin
                    n_ent   = r_ent + 1'b1;
                    n_state = ST_SEARCH;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_table[i] <= '0;
            end
            for (int i = 0; i < SEQ_BYTES; i++) begin
                r_read_bytes[i] <= '0;
            end
            r_state      <= ST_IDLE;
            r_ent        <= '0;
            r_pos        <= '0;
            r_bri        <= '0;
            r_cur_entry  <= '0;
            r_cmp_pos    <= '0;
            r_pending    <= 1'b0;
            r_first_code <= FIRST_KEY_CODE_RST;
            r_out_valid  <= 1'b0;
            r_out_value  <= '0;
            r_out_seq    <= 1'b0;
        end else begin
            if (w_in_acc && (s_axis_tuser == OP_TABLE_WRITE) &&
                    ({1'b0, w_idx} < (IDX_W + 1)'(TABLE_ENTRIES))) begin
                r_table[w_idx[EW-1:0]] <= w_bytes;
            end
            if (i_cfg_valid) begin
                r_first_code <= i_cfg_data;
            end
            r_read_bytes <= n_read_bytes;
            r_state      <= n_state;
            r_ent        <= n_ent;
            r_pos        <= n_pos;
            r_bri        <= n_bri;
            r_cur_entry  <= n_cur_entry;
            r_cmp_pos    <= n_cmp_pos;
            r_pending    <= n_pending;
            r_out_valid  <= n_out_valid;
            r_out_value  <= n_out_value;
            r_out_seq    <= n_out_seq;
        end
    end

    a_key_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (s_axis_tuser == OP_KEY_BYTE)) |=> (r_state != ST_IDLE))
        else $error("key byte accepted but sequencer stayed idle");

    a_pending_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> ((r_cmp_pos != 2'd0) && (r_cmp_pos > r_bri)))
        else $error("pending match waits at an impossible byte position");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> (($past(r_state) == ST_SEARCH) || ($past(r_state) == ST_ADV)))
        else $error("result raised outside a search or compare step");

    a_adv_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADV) |-> (r_ent < ENT_END))
        else $error("compare step on an entry beyond the table");

endmodule

// ===== test/key_sequence_matcher_top_test.sv =====
// Self-checking testbench for key_sequence_matcher_top: predicts every decoded key
// from a software copy of the sequence table and compares it with the output stream.
// Depends on ksm_pkg and key_sequence_matcher_top.
`timescale 1ns / 1ps

module key_sequence_matcher_top_test
    import ksm_pkg::*;
();

    localparam int unsigned TABLE_ENTRIES  = 17;
    localparam int unsigned SETTLE_CYCLES  = 100;
    localparam int unsigned CYCLE_LIMIT    = 1_000_000;
    localparam int unsigned ITEMS_PER_PASS = 425;

    // Tracks the table and the partial sequence, and holds the keys still to be seen.
    class key_code_tracker;
        localparam int unsigned ENTRIES = TABLE_ENTRIES;

        typedef struct packed {
            ksm_pkg::t_byte code;
            logic           is_seq;
        } t_key_result;

        logic [31:0]    entry_words [ENTRIES];
        ksm_pkg::t_byte held_bytes [4];
        int unsigned    last_held;
        int unsigned    cand_entry;
        int unsigned    cmp_pos;
        bit             seq_pending;
        ksm_pkg::t_byte first_code;
        t_key_result    expected_keys [$];
        int unsigned    error_count;

        function new();
            foreach (entry_words[i]) entry_words[i] = '0;
            foreach (held_bytes[i]) held_bytes[i] = '0;
            last_held   = 0;
            cand_entry  = 0;
            cmp_pos     = 0;
            seq_pending = 1'b0;
            first_code  = ksm_pkg::FIRST_KEY_CODE_RST;
            error_count = 0;
        endfunction

        function ksm_pkg::t_byte table_byte(int unsigned e, int unsigned k);
            if (e >= ENTRIES || k > 3) return '0;
            return entry_words[e][8*k +: 8];
        endfunction

        function int unsigned first_entry_from(int unsigned start, ksm_pkg::t_byte lead);
            int unsigned e = start;
            while (e < ENTRIES && table_byte(e, 0) != lead) e++;
            return e;
        endfunction

        function void give_key(ksm_pkg::t_byte code, logic is_seq);
            t_key_result r;
            r.code      = code;
            r.is_seq    = is_seq;
            expected_keys.push_back(r);
            seq_pending = 1'b0;
        endfunction

        // Walks the candidates from the current entry and position. A mismatch moves on
        // to the next entry with the same lead byte and compares the buffered bytes again.
        function void walk_candidates();
            int unsigned    cur = cand_entry;
            int unsigned    pos = cmp_pos;
            ksm_pkg::t_byte t;
            while (pos < 4) begin
                t = table_byte(cur, pos);
                if (t == 0) begin
                    give_key(ksm_pkg::t_byte'(first_code + cur), 1'b1);
                    return;
                end
                if (pos > last_held) begin
                    cand_entry  = cur;
                    cmp_pos     = pos;
                    seq_pending = 1'b1;
                    return;
                end
                if (t != held_bytes[pos]) begin
                    cur = first_entry_from(cur + 1, held_bytes[0]);
                    if (cur >= ENTRIES) begin
                        give_key(held_bytes[last_held], 1'b0);
                        return;
                    end
                    pos = 1;
                end else begin
                    pos++;
                end
            end
            give_key(ksm_pkg::t_byte'(first_code + cur), 1'b1);
        endfunction

        function void note_item(logic op, logic [4:0] idx, logic [31:0] word,
                                ksm_pkg::t_byte key);
            int unsigned e;
            if (op == ksm_pkg::OP_TABLE_WRITE) begin
                if (idx < ENTRIES) entry_words[idx] = word;
                return;
            end
            if (seq_pending) begin
                held_bytes[cmp_pos] = key;
                last_held           = cmp_pos;
                walk_candidates();
                return;
            end
            held_bytes[0] = key;
            last_held     = 0;
            e = first_entry_from(0, key);
            if (e >= ENTRIES) begin
                give_key(key, 1'b0);
                return;
            end
            cand_entry = e;
            cmp_pos    = 1;
            walk_candidates();
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t ns: %s", $time, msg);
            error_count++;
        endtask

        task check_key(ksm_pkg::t_byte code, logic is_seq);
            t_key_result want;
            if (expected_keys.size() == 0) begin
                report_mismatch($sformatf("key %02h (sequence %0b) with none expected",
                                          code, is_seq));
                return;
            end
            want = expected_keys.pop_front();
            if (code !== want.code)
                report_mismatch($sformatf("key value %02h, expected %02h", code, want.code));
            if (is_seq !== want.is_seq)
                report_mismatch($sformatf("sequence flag %0b, expected %0b", is_seq,
                                          want.is_seq));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic                  s_axis_tuser = OP_KEY_BYTE;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [KEY_W-1:0]      m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [KEY_W-1:0]      i_cfg_data = '0;

    key_code_tracker tracker = new();
    int unsigned src_idle_pct = 25;
    int unsigned snk_idle_pct = 87;
    int unsigned sent_items = 0;
    int unsigned cycle_count = 0;

    key_sequence_matcher_top #(.TABLE_ENTRIES(TABLE_ENTRIES)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_key(m_axis_tdata, m_axis_tuser);
    end

    // Called at a falling edge; returns at the falling edge after the item was taken.
    // Valid is left high so that back-to-back items need no second assignment.
    task automatic send_item(logic op, logic [4:0] idx, logic [31:0] word, t_byte key);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, key, word, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_item(op, idx, word, key);
        if (op == OP_KEY_BYTE || idx < TABLE_ENTRIES) sent_items++;
        @(negedge i_clk);
    endtask

    task automatic send_key(t_byte key);
        send_item(OP_KEY_BYTE, 5'($urandom_range(31)), $urandom(), key);
    endtask

    task automatic send_write(logic [4:0] idx, logic [31:0] word);
        send_item(OP_TABLE_WRITE, idx, word, t_byte'($urandom_range(255)));
    endtask

    // Lowers valid, waits for every expected key and then for any silent work to end.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.expected_keys.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_first_code(t_byte code);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= code;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.first_code = code;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // A small alphabet for the bytes after the lead, so that entries share prefixes.
    function automatic t_byte tail_byte();
        case ($urandom_range(7))
            0: return 8'h5B;
            1: return 8'h4F;
            2: return 8'h41;
            3: return 8'h42;
            4: return 8'h31;
            5: return 8'h7E;
            6: return 8'h35;
            default: return t_byte'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic logic [31:0] make_entry();
        logic [31:0] w;
        int unsigned len;
        w = $urandom();
        if ($urandom_range(9) == 0) return w;
        case ($urandom_range(11))
            0, 1, 2, 3, 4, 5: w[7:0] = 8'h1B;
            6, 7:             w[7:0] = 8'h9B;
            8:                w[7:0] = 8'h8F;
            9, 10:            w[7:0] = t_byte'($urandom_range(255));
            default:          w[7:0] = 8'h00;
        endcase
        len = $urandom_range(1, 4);
        for (int unsigned k = 1; k < len; k++) w[8*k +: 8] = tail_byte();
        if (len < 4) w[8*len +: 8] = 8'h00;
        return w;
    endfunction

    // Sends the bytes of one entry up to its end; a byte at break_pos is replaced.
    task automatic send_entry_keys(int unsigned e, int unsigned break_pos);
        t_byte b;
        for (int unsigned pos = 0; pos < 4; pos++) begin
            b = tracker.table_byte(e, pos);
            if (pos > 0 && b == 0) break;
            if (pos == break_pos) b = tail_byte();
            send_key(b);
        end
    endtask

    task automatic random_pass(int unsigned src_pct, int unsigned snk_pct, t_byte code);
        int unsigned goal;
        int unsigned pick;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        drain();
        write_first_code(code);
        for (int unsigned i = 0; i < TABLE_ENTRIES; i++) send_write(5'(i), make_entry());
        send_write(5'($urandom_range(TABLE_ENTRIES, 31)), make_entry());
        goal = sent_items + ITEMS_PER_PASS;
        while (sent_items < goal) begin
            pick = $urandom_range(99);
            if (pick < 55)
                send_entry_keys($urandom_range(TABLE_ENTRIES - 1), 4);
            else if (pick < 70)
                send_entry_keys($urandom_range(TABLE_ENTRIES - 1), $urandom_range(1, 3));
            else if (pick < 82)
                send_key(t_byte'($urandom_range(255)));
            else if (pick < 90)
                send_key(tail_byte());
            else
                send_write(5'($urandom_range(31)), make_entry());
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table: a plain byte passes through, a zero byte hits entry zero at once.
        send_key(8'h41);
        send_key(8'h00);
        send_write(5'd0, 32'h00415B1B);
        send_write(5'd1, 32'h00425B1B);
        send_write(5'd2, 32'h51504F1B);
        send_write(5'd16, 32'h000000FF);
        // Out of range, so the table must not change.
        send_write(5'd31, 32'h000000AA);
        send_key(8'h1B);
        send_key(8'h5B);
        send_key(8'h42);
        send_key(8'h1B);
        send_key(8'h4F);
        send_key(8'h50);
        send_key(8'h51);
        send_key(8'hAA);
        send_key(8'hFF);
        // No entry left: the last byte comes out raw.
        send_key(8'h1B);
        send_key(8'h5B);
        send_key(8'h43);
        // A table write in the middle of a sequence is seen by the later compares.
        send_key(8'h1B);
        send_write(5'd1, 32'h0000581B);
        send_key(8'h58);
        send_key(8'h00);
        drain();
        // The largest code makes the sum wrap.
        write_first_code(8'hFF);
        send_key(8'hFF);
        send_key(8'h1B);
        send_key(8'h5B);
        send_key(8'h41);

        random_pass(25, 87, 8'h00);
        random_pass(87, 25, 8'd250);
        random_pass(0, 0, t_byte'($urandom_range(1, 254)));

        drain();
        if (tracker.error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/ksm_pkg.sv
hw/rtl/key_sequence_matcher_top.sv
test/key_sequence_matcher_top_test.sv
